// ===== design/particle_euler_update_assert.svh =====
`ifndef PARTICLE_EULER_UPDATE_ASSERT_SVH
`define PARTICLE_EULER_UPDATE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PEU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PEU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/peu_pkg.sv =====
package peu_pkg;

    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 17;
    localparam int ACC_W        = 26;
    localparam int CXY_W        = 34;

    localparam logic [15:0] TIME_STEP_RST = 16'd1092;
    localparam logic [30:0] GRAVITY_RST   = 31'd106168;

    localparam logic signed [ACC_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ACC_W-1:0] DEG180 = 26'sd11796480;
    localparam logic [17:0] AGE_MAX = 18'h3FFFF;

    typedef enum logic [2:0] {
        REG_TIME_STEP = 3'd0,
        REG_FLOOR     = 3'd1,
        REG_GRAVITY   = 3'd2,
        REG_CAM_X     = 3'd3,
        REG_CAM_Y     = 3'd4,
        REG_CAM_Z     = 3'd5
    } reg_idx_t;

    // atan(2^-i) in Q16.16 degrees
    localparam logic [21:0] ATAN_DEG [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117303,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57
    };

    // particle fields that ride along the angle pipeline
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [17:0] age;
        logic        expired;
        logic [31:0] axis_x;
        logic [31:0] axis_y;
        logic        zero;
    } rec_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'h7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round half up to 16 fractional bits
    function automatic logic signed [33:0] rnd16(input logic signed [48:0] p);
        logic signed [48:0] t;
        t = p + 49'sd32768;
        return {t[48], t[48:16]};
    endfunction

endpackage

// ===== design/particle_euler_update.sv =====
// Throughput: one particle per cycle; the whole pipeline advances together
// and freezes only while a result is held by out_stall.
// The angle path (31-stage square root, 17-stage CORDIC) sets the depth.
// Reset clears all valid bits and loads the register reset values; no sweep.
`include "particle_euler_update_assert.svh"

module particle_euler_update
    import peu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [17:0] age,
    input  logic [19:0] decay_rate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic [17:0] new_age,
    output logic signed [31:0] axis_x,
    output logic signed [31:0] axis_y,
    output logic [15:0] facing_angle,
    output logic        expired
);

    // ---------------- configuration ----------------
    logic [15:0]        time_step_reg;
    logic signed [31:0] floor_reg;
    logic [30:0]        gravity_reg;
    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RST;
            floor_reg     <= '0;
            gravity_reg   <= GRAVITY_RST;
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            cam_z_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TIME_STEP: time_step_reg <= cfg_data[15:0];
                REG_FLOOR:     floor_reg     <= $signed(cfg_data);
                REG_GRAVITY:   gravity_reg   <= cfg_data[30:0];
                REG_CAM_X:     cam_x_reg     <= $signed(cfg_data);
                REG_CAM_Y:     cam_y_reg     <= $signed(cfg_data);
                REG_CAM_Z:     cam_z_reg     <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    logic signed [16:0] dt_s;
    assign dt_s = $signed({1'b0, time_step_reg});

    // ---------------- flow control ----------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // ---------------- S1: products ----------------
    logic               s1_v_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg, s1_vx_reg, s1_vy_reg, s1_vz_reg;
    logic [17:0]        s1_age_reg;
    logic [46:0]        s1_gdt_reg;
    logic signed [48:0] s1_vxdt_reg, s1_vzdt_reg;
    logic [35:0]        s1_ddt_reg;

    // ---------------- S2: velocity, x/z position, age ----------------
    logic               s2_v_reg;
    logic signed [31:0] s2_px_reg, s2_py_reg, s2_pz_reg, s2_vx_reg, s2_vy_reg, s2_vz_reg;
    logic [17:0]        s2_age_reg;
    logic               s2_exp_reg;

    logic [47:0]        g_rnd_w;
    logic signed [33:0] vy_sum, px_sum, pz_sum;
    logic [36:0]        d_rnd_w;
    logic [21:0]        age_sum;

    assign g_rnd_w = {1'b0, s1_gdt_reg} + 48'd32768;
    assign vy_sum  = {{2{s1_vy_reg[31]}}, s1_vy_reg} - $signed({3'b000, g_rnd_w[46:16]});
    assign px_sum  = {{2{s1_px_reg[31]}}, s1_px_reg} + rnd16(s1_vxdt_reg);
    assign pz_sum  = {{2{s1_pz_reg[31]}}, s1_pz_reg} + rnd16(s1_vzdt_reg);
    assign d_rnd_w = {1'b0, s1_ddt_reg} + 37'd32768;
    assign age_sum = {4'b0000, s1_age_reg} + {1'b0, d_rnd_w[36:16]};

    // ---------------- S3: vy * dt ----------------
    logic               s3_v_reg;
    logic signed [31:0] s3_px_reg, s3_py_reg, s3_pz_reg, s3_vx_reg, s3_vy_reg, s3_vz_reg;
    logic [17:0]        s3_age_reg;
    logic               s3_exp_reg;
    logic signed [48:0] s3_vydt_reg;

    // ---------------- S4: y position and floor clamp ----------------
    logic               s4_v_reg;
    logic signed [31:0] s4_px_reg, s4_py_reg, s4_pz_reg, s4_vx_reg, s4_vy_reg, s4_vz_reg;
    logic [17:0]        s4_age_reg;
    logic               s4_exp_reg;

    logic signed [31:0] py_sat;
    assign py_sat = $signed(sat32({{2{s3_py_reg[31]}}, s3_py_reg} + rnd16(s3_vydt_reg)));

    // ---------------- S5: camera offset, axis ----------------
    logic               s5_v_reg;
    rec_t               s5_rec_reg;
    logic signed [32:0] s5_ex_reg, s5_ey_reg, s5_ez_reg;

    logic signed [32:0] ex_w, ey_w, ez_w;
    rec_t               s5_rec_next;

    assign ex_w = {s4_px_reg[31], s4_px_reg} - {cam_x_reg[31], cam_x_reg};
    assign ey_w = {s4_py_reg[31], s4_py_reg} - {cam_y_reg[31], cam_y_reg};
    assign ez_w = {s4_pz_reg[31], s4_pz_reg} - {cam_z_reg[31], cam_z_reg};

    always_comb
    begin
        s5_rec_next.px      = s4_px_reg;
        s5_rec_next.py      = s4_py_reg;
        s5_rec_next.pz      = s4_pz_reg;
        s5_rec_next.vx      = s4_vx_reg;
        s5_rec_next.vy      = s4_vy_reg;
        s5_rec_next.vz      = s4_vz_reg;
        s5_rec_next.age     = s4_age_reg;
        s5_rec_next.expired = s4_exp_reg;
        s5_rec_next.axis_x  = sat32(-{ey_w[32], ey_w});
        s5_rec_next.axis_y  = sat32({ex_w[32], ex_w});
        s5_rec_next.zero    = (ex_w == '0) && (ey_w == '0) && (ez_w == '0);
    end

    // ---------------- S6: range reduction ----------------
    logic               s6_v_reg;
    rec_t               s6_rec_reg;
    logic signed [30:0] s6_sx_reg, s6_sy_reg, s6_sz_reg;

    logic [32:0]        abs_x, abs_y, abs_z, abs_or;
    logic [1:0]         shamt;
    logic signed [32:0] shx, shy, shz;

    always_comb
    begin
        abs_x  = s5_ex_reg[32] ? 33'(-s5_ex_reg) : s5_ex_reg;
        abs_y  = s5_ey_reg[32] ? 33'(-s5_ey_reg) : s5_ey_reg;
        abs_z  = s5_ez_reg[32] ? 33'(-s5_ez_reg) : s5_ez_reg;
        abs_or = abs_x | abs_y | abs_z;
        // smallest shift that brings every magnitude below 2^30
        if (abs_or[32])
            shamt = 2'd3;
        else if (abs_or[31])
            shamt = 2'd2;
        else if (abs_or[30])
            shamt = 2'd1;
        else
            shamt = 2'd0;
        shx = s5_ex_reg >>> shamt;
        shy = s5_ey_reg >>> shamt;
        shz = s5_ez_reg >>> shamt;
    end

    // ---------------- S7: squares ----------------
    logic               s7_v_reg;
    rec_t               s7_rec_reg;
    logic [60:0]        s7_qx_reg, s7_qy_reg;
    logic signed [30:0] s7_sz_reg;

    logic signed [61:0] qx_w, qy_w;
    assign qx_w = s6_sx_reg * s6_sx_reg;
    assign qy_w = s6_sy_reg * s6_sy_reg;

    // ---------------- square root, one bit per stage ----------------
    logic               sq_v_reg    [SQRT_STEPS+1];
    rec_t               sq_rec_reg  [SQRT_STEPS+1];
    logic [61:0]        sq_rem_reg  [SQRT_STEPS+1];
    logic [30:0]        sq_root_reg [SQRT_STEPS+1];
    logic signed [30:0] sq_z_reg    [SQRT_STEPS+1];

    // ---------------- CORDIC ----------------
    logic                    cr_v_reg   [CORDIC_STEPS+1];
    rec_t                    cr_rec_reg [CORDIC_STEPS+1];
    logic signed [CXY_W-1:0] cr_x_reg   [CORDIC_STEPS+1];
    logic signed [CXY_W-1:0] cr_y_reg   [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0] cr_acc_reg [CORDIC_STEPS+1];

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            sq_v_reg[0]   <= 1'b0;
            cr_v_reg[0]   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            sq_v_reg[0]   <= s7_v_reg;
            cr_v_reg[0]   <= sq_v_reg[SQRT_STEPS];
            out_valid_reg <= cr_v_reg[CORDIC_STEPS];
        end
    end

    // ---------------- front-end payload ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg   <= pos_x;
            s1_py_reg   <= pos_y;
            s1_pz_reg   <= pos_z;
            s1_vx_reg   <= vel_x;
            s1_vy_reg   <= vel_y;
            s1_vz_reg   <= vel_z;
            s1_age_reg  <= age;
            s1_gdt_reg  <= gravity_reg * time_step_reg;
            s1_vxdt_reg <= vel_x * dt_s;
            s1_vzdt_reg <= vel_z * dt_s;
            s1_ddt_reg  <= decay_rate * time_step_reg;

            s2_px_reg  <= $signed(sat32(px_sum));
            s2_py_reg  <= s1_py_reg;
            s2_pz_reg  <= $signed(sat32(pz_sum));
            s2_vx_reg  <= s1_vx_reg;
            s2_vy_reg  <= $signed(sat32(vy_sum));
            s2_vz_reg  <= s1_vz_reg;
            s2_age_reg <= (age_sum > {4'b0000, AGE_MAX}) ? AGE_MAX : age_sum[17:0];
            s2_exp_reg <= (age_sum >= 22'd65536);

            s3_px_reg   <= s2_px_reg;
            s3_py_reg   <= s2_py_reg;
            s3_pz_reg   <= s2_pz_reg;
            s3_vx_reg   <= s2_vx_reg;
            s3_vy_reg   <= s2_vy_reg;
            s3_vz_reg   <= s2_vz_reg;
            s3_age_reg  <= s2_age_reg;
            s3_exp_reg  <= s2_exp_reg;
            s3_vydt_reg <= s2_vy_reg * dt_s;

            s4_px_reg  <= s3_px_reg;
            s4_py_reg  <= (py_sat < floor_reg) ? floor_reg : py_sat;
            s4_pz_reg  <= s3_pz_reg;
            s4_vx_reg  <= s3_vx_reg;
            s4_vy_reg  <= s3_vy_reg;
            s4_vz_reg  <= s3_vz_reg;
            s4_age_reg <= s3_age_reg;
            s4_exp_reg <= s3_exp_reg;

            s5_rec_reg <= s5_rec_next;
            s5_ex_reg  <= ex_w;
            s5_ey_reg  <= ey_w;
            s5_ez_reg  <= ez_w;

            s6_rec_reg <= s5_rec_reg;
            s6_sx_reg  <= shx[30:0];
            s6_sy_reg  <= shy[30:0];
            s6_sz_reg  <= shz[30:0];

            s7_rec_reg <= s6_rec_reg;
            s7_qx_reg  <= qx_w[60:0];
            s7_qy_reg  <= qy_w[60:0];
            s7_sz_reg  <= s6_sz_reg;

            sq_rec_reg[0]  <= s7_rec_reg;
            sq_rem_reg[0]  <= {1'b0, s7_qx_reg} + {1'b0, s7_qy_reg};
            sq_root_reg[0] <= '0;
            sq_z_reg[0]    <= s7_sz_reg;
        end
    end

    // ---------------- square root stages ----------------
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - j;
        logic [62:0] trial;
        logic        take;

        assign trial = ({32'd0, sq_root_reg[j]} << (B + 1)) + (63'd1 << (2 * B));
        assign take  = ({1'b0, sq_rem_reg[j]} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else if (en)
                sq_v_reg[j+1] <= sq_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rec_reg[j+1]  <= sq_rec_reg[j];
                sq_z_reg[j+1]    <= sq_z_reg[j];
                sq_rem_reg[j+1]  <= take ? 62'({1'b0, sq_rem_reg[j]} - trial) : sq_rem_reg[j];
                sq_root_reg[j+1] <= take ? (sq_root_reg[j] | (31'd1 << B)) : sq_root_reg[j];
            end
        end
    end

    // ---------------- CORDIC entry: fold negative z into the first quadrant ----------------
    logic signed [CXY_W-1:0] r_ext, z_ext;
    assign r_ext = $signed({3'b000, sq_root_reg[SQRT_STEPS]});
    assign z_ext = {{(CXY_W-31){sq_z_reg[SQRT_STEPS][30]}}, sq_z_reg[SQRT_STEPS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_rec_reg[0] <= sq_rec_reg[SQRT_STEPS];
            if (z_ext < 0)
            begin
                cr_x_reg[0]   <= r_ext;
                cr_y_reg[0]   <= -z_ext;
                cr_acc_reg[0] <= DEG90;
            end
            else
            begin
                cr_x_reg[0]   <= z_ext;
                cr_y_reg[0]   <= r_ext;
                cr_acc_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        logic signed [CXY_W-1:0] dx, dy;
        logic signed [ACC_W-1:0] ang;

        assign dx  = cr_y_reg[k] >>> k;
        assign dy  = cr_x_reg[k] >>> k;
        assign ang = $signed({4'b0000, ATAN_DEG[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cr_v_reg[k+1] <= 1'b0;
            else if (en)
                cr_v_reg[k+1] <= cr_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_rec_reg[k+1] <= cr_rec_reg[k];
                if (cr_y_reg[k] > 0)
                begin
                    cr_x_reg[k+1]   <= cr_x_reg[k] + dx;
                    cr_y_reg[k+1]   <= cr_y_reg[k] - dy;
                    cr_acc_reg[k+1] <= cr_acc_reg[k] + ang;
                end
                else
                begin
                    cr_x_reg[k+1]   <= cr_x_reg[k] - dx;
                    cr_y_reg[k+1]   <= cr_y_reg[k] + dy;
                    cr_acc_reg[k+1] <= cr_acc_reg[k] - ang;
                end
            end
        end
    end

    // ---------------- output register ----------------
    rec_t               out_rec_reg;
    logic [15:0]        out_ang_reg;
    logic signed [ACC_W-1:0] acc_cl;
    logic [ACC_W-1:0]   acc_rnd;

    always_comb
    begin
        acc_cl = cr_acc_reg[CORDIC_STEPS];
        if (acc_cl < 0)
            acc_cl = '0;
        else if (acc_cl > DEG180)
            acc_cl = DEG180;
        acc_rnd = acc_cl + 26'd128;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rec_reg <= cr_rec_reg[CORDIC_STEPS];
            out_ang_reg <= cr_rec_reg[CORDIC_STEPS].zero ? 16'd0 : acc_rnd[23:8];
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_pos_x    = $signed(out_rec_reg.px);
    assign new_pos_y    = $signed(out_rec_reg.py);
    assign new_pos_z    = $signed(out_rec_reg.pz);
    assign new_vel_x    = $signed(out_rec_reg.vx);
    assign new_vel_y    = $signed(out_rec_reg.vy);
    assign new_vel_z    = $signed(out_rec_reg.vz);
    assign new_age      = out_rec_reg.age;
    assign expired      = out_rec_reg.expired;
    assign axis_x       = $signed(out_rec_reg.axis_x);
    assign axis_y       = $signed(out_rec_reg.axis_y);
    assign facing_angle = out_ang_reg;

    // ---------------- checks ----------------
    `PEU_ASSERT_IMP(a_stall_link, 1'b1, in_stall == (out_valid && out_stall), "stall mismatch")
    `PEU_ASSERT_NXT(a_enter, in_valid && !in_stall, s1_v_reg, "accepted beat lost at entry")
    `PEU_ASSERT_IMP(a_angle_range, out_valid, facing_angle <= 16'd46080, "angle out of range")
    `PEU_ASSERT_IMP(a_expire, out_valid, expired == (new_age >= 18'd65536), "expiry flag wrong")

endmodule
